FILE: rtl/bra_pkg.sv
`timescale 1ns / 1ps
// Package for the blocked random assignment block: item and result types,
// command and status codes. No dependencies.
package bra_pkg;

  localparam logic [1:0] FUNC_LABEL = 2'd0;
  localparam logic [1:0] FUNC_UNIT  = 2'd1;
  localparam logic [1:0] FUNC_DRAW  = 2'd2;
  localparam logic [1:0] FUNC_FETCH = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_READY = 2'd1;
  localparam logic [1:0] STATUS_NO_LABELS = 2'd2;
  localparam logic [1:0] STATUS_CAPACITY  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] value;
    logic [31:0] rand_fraction;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [15:0] treatment;
    logic [9:0]  unit_index;
    logic        last_unit;
    logic [1:0]  status;
  } result_t;

endpackage

FILE: rtl/blocked_random_assignment.sv
`timescale 1ns / 1ps
// Blocked random assignment: label and unit loading, per-block pool fill,
// Fisher-Yates draws and in-order fetch. Depends on bra_pkg.
// Items are taken one at a time, busy high while one is worked on; where an item
// yields a result, it shows on done for one cycle, and the receiver cannot stall.
// Block setup skips empty blocks, else reckons size mod labels, then copies labels
// or fills the pool, until ready. Reset (rst, sync) clears counts and pointers.
module blocked_random_assignment #(
  parameter int MAX_UNITS   = 1024,
  parameter int MAX_BLOCKS  = 64,
  parameter int MAX_LABELS  = 16,
  parameter int LABEL_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bra_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output bra_pkg::result_t result
);

  localparam int UW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CW  = $clog2(MAX_UNITS + 1);
  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NBW = $clog2(MAX_BLOCKS + 1);
  localparam int LW  = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int LCW = $clog2(MAX_LABELS + 1);
  localparam int MCW = $clog2(CW + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RAND  = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INC     = 5'd1;
  localparam logic [4:0] S_BB_RD   = 5'd2;
  localparam logic [4:0] S_BB      = 5'd3;
  localparam logic [4:0] S_MOD     = 5'd4;
  localparam logic [4:0] S_COPY_RD = 5'd5;
  localparam logic [4:0] S_COPY_WR = 5'd6;
  localparam logic [4:0] S_FILL_RD = 5'd7;
  localparam logic [4:0] S_FILL_WR = 5'd8;
  localparam logic [4:0] S_MUL     = 5'd9;
  localparam logic [4:0] S_SW_A    = 5'd10;
  localparam logic [4:0] S_SW_B    = 5'd11;
  localparam logic [4:0] S_SW_C    = 5'd12;
  localparam logic [4:0] S_SW_D    = 5'd13;
  localparam logic [4:0] S_F1      = 5'd14;
  localparam logic [4:0] S_F2      = 5'd15;
  localparam logic [4:0] S_F3      = 5'd16;

  logic [4:0]             state;
  logic [1:0]             phase;
  logic                   stage_shuf;
  logic [LCW-1:0]         lc;
  logic [CW-1:0]          uc;
  logic [NBW-1:0]         nb;
  logic [NBW-1:0]         cur_block;
  logic [CW-1:0]          base;
  logic [CW-1:0]          cur_size;
  logic [CW-1:0]          dp;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          j_reg;
  logic [CW-1:0]          prod_hi;
  logic [CW-1:0]          fetch;
  logic [LCW-1:0]         target;
  logic [LW-1:0]          k;
  logic [BW-1:0]          blk;
  logic                   last_r;
  logic                   from_scr;
  logic                   p_zero;
  logic [31:0]            u_reg;
  logic [CW-1:0]          quo;
  logic [LCW-1:0]         rem;
  logic [MCW-1:0]         mcnt;
  logic [LABEL_WIDTH-1:0] a_data;
  logic [MAX_BLOCKS-1:0]  bs_v;
  logic [MAX_BLOCKS-1:0]  bp_v;

  logic [LABEL_WIDTH-1:0] label_mem [MAX_LABELS];
  logic [LABEL_WIDTH-1:0] scr_mem   [MAX_LABELS];
  logic [BW-1:0]          ubi_mem   [MAX_UNITS];
  logic [CW-1:0]          bs_mem    [MAX_BLOCKS];
  logic [CW-1:0]          bp_mem    [MAX_BLOCKS];
  logic [LABEL_WIDTH-1:0] pool_mem  [MAX_UNITS];

  logic [LABEL_WIDTH-1:0] lab_rd, scr_rd, pool_rd;
  logic [BW-1:0]          ubi_rd;
  logic [CW-1:0]          bs_rd, bp_rd;

  logic                   lw_en, sw_en, uw_en, bsw_en, bpw_en, pw_en;
  logic [LW-1:0]          lw_addr, lr_addr, sw_addr, sr_addr;
  logic [LABEL_WIDTH-1:0] sw_data, pw_data;
  logic [BW-1:0]          bsr_addr, bsw_addr, bpr_addr, bpw_addr;
  logic [CW-1:0]          bsw_data, bpw_data;
  logic [UW-1:0]          pr_addr, pw_addr;

  logic                   acc;
  logic                   ok_label, ok_unit;
  logic                   fin, clear;
  logic [CW-1:0]          bs_val, bp_val, n_cur, diff;
  logic [31+CW:0]         prod;
  logic [LCW:0]           rem_t, rem_step;

  assign busy     = (state != S_IDLE);
  assign acc      = start && !busy;
  assign ok_label = (phase == PH_IDLE) && (lc < LCW'(MAX_LABELS));
  assign ok_unit  = (phase == PH_IDLE) && (uc < CW'(MAX_UNITS)) &&
                    (32'(cmd.value) < 32'(MAX_BLOCKS));
  assign bs_val   = bs_v[BW'(cur_block)] ? bs_rd : '0;
  assign bp_val   = bp_v[blk] ? bp_rd : '0;
  assign fin      = (fetch + CW'(1)) == uc;
  assign clear    = (state == S_INC && last_r && lc == '0) || (state == S_F3 && fin);
  assign n_cur    = stage_shuf ? cur_size : CW'(lc);
  assign diff     = n_cur - dp;
  assign prod     = u_reg * diff;
  assign rem_t    = {rem, quo[CW-1]};
  assign rem_step = (rem_t >= {1'b0, lc}) ? (rem_t - {1'b0, lc}) : rem_t;

  always_comb begin
    lw_en    = acc && cmd.func == bra_pkg::FUNC_LABEL && ok_label;
    lw_addr  = LW'(lc);
    lr_addr  = k;
    uw_en    = acc && cmd.func == bra_pkg::FUNC_UNIT && ok_unit;
    bsr_addr = (state == S_IDLE) ? BW'(cmd.value) : BW'(cur_block);
    bsw_en   = (state == S_INC);
    bsw_addr = blk;
    bsw_data = bs_val + CW'(1);
    bpr_addr = ubi_rd;
    bpw_en   = 1'b0;
    bpw_addr = BW'(cur_block);
    bpw_data = base + bs_val;
    sw_en    = 1'b0;
    sw_addr  = k;
    sw_data  = lab_rd;
    sr_addr  = LW'(pos);
    pw_en    = 1'b0;
    pw_addr  = UW'(base + pos);
    pw_data  = from_scr ? scr_rd : lab_rd;
    pr_addr  = UW'(base + dp);
    case (state)
      S_BB:      bpw_en = 1'b1;
      S_COPY_WR: sw_en = 1'b1;
      S_FILL_WR: pw_en = 1'b1;
      S_SW_A:    sr_addr = LW'(dp);
      S_SW_B: begin
        sr_addr = LW'(j_reg);
        pr_addr = UW'(base + j_reg);
      end
      S_SW_C: begin
        sw_en   = !stage_shuf;
        sw_addr = LW'(dp);
        sw_data = scr_rd;
        pw_en   = stage_shuf;
        pw_addr = UW'(base + dp);
        pw_data = pool_rd;
      end
      S_SW_D: begin
        sw_en   = !stage_shuf;
        sw_addr = LW'(j_reg);
        sw_data = a_data;
        pw_en   = stage_shuf;
        pw_addr = UW'(base + j_reg);
        pw_data = a_data;
      end
      S_F2: begin
        pr_addr  = UW'(bp_val - CW'(1));
        bpw_en   = (bp_val != '0);
        bpw_addr = blk;
        bpw_data = bp_val - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en) label_mem[lw_addr] <= LABEL_WIDTH'(cmd.value);
    lab_rd <= label_mem[lr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) scr_mem[sw_addr] <= sw_data;
    scr_rd <= scr_mem[sr_addr];
  end

  always_ff @(posedge clk) begin
    if (uw_en) ubi_mem[UW'(uc)] <= BW'(cmd.value);
    ubi_rd <= ubi_mem[UW'(fetch)];
  end

  always_ff @(posedge clk) begin
    if (bsw_en) bs_mem[bsw_addr] <= bsw_data;
    bs_rd <= bs_mem[bsr_addr];
  end

  always_ff @(posedge clk) begin
    if (bpw_en) bp_mem[bpw_addr] <= bpw_data;
    bp_rd <= bp_mem[bpr_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) pool_mem[pw_addr] <= pw_data;
    pool_rd <= pool_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_IDLE;
      stage_shuf <= 1'b0;
      lc         <= '0;
      uc         <= '0;
      nb         <= '0;
      cur_block  <= '0;
      base       <= '0;
      dp         <= '0;
      target     <= '0;
      fetch      <= '0;
      bs_v       <= '0;
      bp_v       <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (bsw_en) bs_v[bsw_addr] <= 1'b1;
      if (bpw_en) bp_v[bpw_addr] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            result <= '{treatment: '0, unit_index: '0, last_unit: 1'b0,
                        status: bra_pkg::STATUS_NOT_READY};
            case (cmd.func)
              bra_pkg::FUNC_LABEL: begin
                if (phase != PH_IDLE) begin
                  done <= 1'b1;
                end else if (!ok_label) begin
                  done          <= 1'b1;
                  result.status <= bra_pkg::STATUS_CAPACITY;
                end else begin
                  lc <= lc + LCW'(1);
                end
              end
              bra_pkg::FUNC_UNIT: begin
                if (phase != PH_IDLE) begin
                  done <= 1'b1;
                end else if (!ok_unit) begin
                  done          <= 1'b1;
                  result.status <= bra_pkg::STATUS_CAPACITY;
                end else begin
                  uc        <= uc + CW'(1);
                  blk       <= BW'(cmd.value);
                  last_r    <= cmd.last;
                  cur_block <= NBW'(cmd.value);
                  if (32'(cmd.value) + 32'd1 > 32'(nb)) nb <= NBW'(32'(cmd.value) + 32'd1);
                  state     <= S_INC;
                end
              end
              bra_pkg::FUNC_DRAW: begin
                if (phase != PH_RAND) begin
                  done <= 1'b1;
                end else begin
                  u_reg <= cmd.rand_fraction;
                  state <= S_MUL;
                end
              end
              default: begin
                if (phase != PH_READY || fetch >= uc) begin
                  done <= 1'b1;
                end else begin
                  state <= S_F1;
                end
              end
            endcase
          end
        end
        S_INC: begin
          state <= S_IDLE;
          if (last_r) begin
            if (lc == '0) begin
              done          <= 1'b1;
              result.status <= bra_pkg::STATUS_NO_LABELS;
            end else begin
              phase     <= PH_RAND;
              cur_block <= '0;
              base      <= '0;
              state     <= S_BB_RD;
            end
          end
        end
        S_BB_RD: begin
          if (cur_block >= nb) begin
            phase <= PH_READY;
            fetch <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_BB;
          end
        end
        S_BB: begin
          cur_size <= bs_val;
          if (bs_val == '0) begin
            cur_block <= cur_block + NBW'(1);
            state     <= S_BB_RD;
          end else begin
            dp    <= '0;
            quo   <= bs_val;
            rem   <= '0;
            mcnt  <= MCW'(CW);
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rem  <= LCW'(rem_step);
          quo  <= quo << 1;
          mcnt <= mcnt - MCW'(1);
          if (mcnt == MCW'(1)) begin
            target <= LCW'(rem_step);
            pos    <= '0;
            k      <= '0;
            state  <= (rem_step != '0) ? S_COPY_RD : S_FILL_RD;
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          if (LCW'(k) + LCW'(1) == lc) begin
            stage_shuf <= 1'b0;
            dp         <= '0;
            state      <= S_IDLE;
          end else begin
            k     <= k + LW'(1);
            state <= S_COPY_RD;
          end
        end
        S_FILL_RD: begin
          from_scr <= pos < CW'(target);
          state    <= S_FILL_WR;
        end
        S_FILL_WR: begin
          if (!from_scr) k <= (LCW'(k) + LCW'(1) == lc) ? '0 : k + LW'(1);
          if (pos + CW'(1) == cur_size) begin
            stage_shuf <= 1'b1;
            dp         <= '0;
            state      <= S_IDLE;
          end else begin
            pos   <= pos + CW'(1);
            state <= S_FILL_RD;
          end
        end
        S_MUL: begin
          prod_hi <= prod[31+CW:32];
          state   <= S_SW_A;
        end
        S_SW_A: begin
          j_reg <= dp + prod_hi;
          state <= S_SW_B;
        end
        S_SW_B: begin
          a_data <= stage_shuf ? pool_rd : scr_rd;
          state  <= S_SW_C;
        end
        S_SW_C: state <= S_SW_D;
        S_SW_D: begin
          if (!stage_shuf) begin
            if (dp + CW'(1) >= CW'(target)) begin
              dp    <= '0;
              pos   <= '0;
              k     <= '0;
              state <= S_FILL_RD;
            end else begin
              dp    <= dp + CW'(1);
              state <= S_IDLE;
            end
          end else if (dp + CW'(1) >= cur_size) begin
            base      <= base + cur_size;
            cur_block <= cur_block + NBW'(1);
            state     <= S_BB_RD;
          end else begin
            dp    <= dp + CW'(1);
            state <= S_IDLE;
          end
        end
        S_F1: begin
          blk   <= ubi_rd;
          state <= S_F2;
        end
        S_F2: begin
          p_zero <= (bp_val == '0);
          state  <= S_F3;
        end
        S_F3: begin
          done   <= 1'b1;
          result <= '{treatment: p_zero ? 16'd0 : 16'(pool_rd),
                      unit_index: 10'(fetch), last_unit: fin,
                      status: bra_pkg::STATUS_OK};
          fetch  <= fetch + CW'(1);
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (clear) begin
        lc         <= '0;
        uc         <= '0;
        bs_v       <= '0;
        bp_v       <= '0;
        phase      <= PH_IDLE;
        stage_shuf <= 1'b0;
        cur_block  <= '0;
        nb         <= '0;
        base       <= '0;
        dp         <= '0;
        target     <= '0;
        fetch      <= '0;
      end
    end
  end

endmodule

FILE: tb/sv/bra_checker.sv
`timescale 1ns / 1ps
// Checker for the blocked random assignment block: watches the command and
// result channels, predicts each result and compares it. Depends on bra_pkg.
module bra_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bra_pkg::cmd_t    cmd,
  input  logic             busy,
  input  logic             done,
  input  bra_pkg::result_t result,
  output int               errors,
  output int               pending
);

  typedef enum logic [1:0] {PH_IDLE, PH_RAND, PH_READY} phase_e;
  typedef enum logic {STG_SAMPLE, STG_SHUFFLE} stage_e;

  logic [15:0]      labels [16];
  logic [15:0]      scratch [16];
  logic [5:0]       unit_blk [1024];
  logic [15:0]      pool [1024];
  int               blk_size [64];
  int               blk_ptr [64];
  int               n_labels, n_units, cur_blk, n_blks, base, dpos, target, fpos;
  phase_e           phase;
  stage_e           stage;
  bra_pkg::result_t expected_q [$];

  assign pending = expected_q.size();

  function automatic bra_pkg::result_t status_only(logic [1:0] st);
    bra_pkg::result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic clear_state();
    n_labels = 0;
    n_units = 0;
    for (int b = 0; b < 64; b++) begin
      blk_size[b] = 0;
      blk_ptr[b] = 0;
    end
    for (int k = 0; k < 16; k++) scratch[k] = '0;
    phase = PH_IDLE;
    stage = STG_SAMPLE;
    cur_blk = 0;
    n_blks = 0;
    base = 0;
    dpos = 0;
    target = 0;
    fpos = 0;
  endtask

  task automatic pool_put(int pos, logic [15:0] v);
    if (pos < 1024) pool[pos] = v;
  endtask

  task automatic fill_pool(int size, int rem);
    int pos;
    pos = 0;
    for (int k = 0; k < rem && k < 16; k++) begin
      pool_put(base + pos, scratch[k]);
      pos++;
    end
    while (pos < size) begin
      for (int k = 0; k < n_labels && k < 16 && pos < size; k++) begin
        pool_put(base + pos, labels[k]);
        pos++;
      end
    end
  endtask

  task automatic next_block();
    int s;
    while (cur_blk < n_blks && cur_blk < 64) begin
      s = blk_size[cur_blk];
      blk_ptr[cur_blk] = base + s;
      if (s == 0) begin
        cur_blk++;
        continue;
      end
      dpos = 0;
      target = s % n_labels;
      if (target != 0) begin
        for (int k = 0; k < 16; k++) scratch[k] = labels[k];
        stage = STG_SAMPLE;
      end else begin
        fill_pool(s, 0);
        stage = STG_SHUFFLE;
      end
      return;
    end
    phase = PH_READY;
    fpos = 0;
  endtask

  task automatic apply_draw(logic [31:0] u);
    int s, n, j;
    logic [63:0] prod;
    logic [15:0] t;
    s = blk_size[cur_blk];
    n = (stage == STG_SAMPLE) ? n_labels : s;
    prod = {32'd0, u} * 64'(n - dpos);
    j = dpos + int'(prod[63:32]);
    if (stage == STG_SAMPLE) begin
      if (dpos < 16 && j < 16) begin
        t = scratch[dpos];
        scratch[dpos] = scratch[j];
        scratch[j] = t;
      end
      dpos++;
      if (dpos >= target) begin
        fill_pool(s, target);
        stage = STG_SHUFFLE;
        dpos = 0;
      end
    end else begin
      if (base + dpos < 1024 && base + j < 1024) begin
        t = pool[base + dpos];
        pool[base + dpos] = pool[base + j];
        pool[base + j] = t;
      end
      dpos++;
      if (dpos >= s) begin
        base += s;
        cur_blk++;
        next_block();
      end
    end
  endtask

  task automatic predict_item(bra_pkg::cmd_t c);
    bra_pkg::result_t r;
    int b, p, idx;
    case (c.func)
      bra_pkg::FUNC_LABEL: begin
        if (phase != PH_IDLE)
          expected_q.push_back(status_only(bra_pkg::STATUS_NOT_READY));
        else if (n_labels >= 16)
          expected_q.push_back(status_only(bra_pkg::STATUS_CAPACITY));
        else begin
          labels[n_labels] = c.value;
          n_labels++;
        end
      end
      bra_pkg::FUNC_UNIT: begin
        if (phase != PH_IDLE)
          expected_q.push_back(status_only(bra_pkg::STATUS_NOT_READY));
        else if (n_units >= 1024 || c.value >= 64)
          expected_q.push_back(status_only(bra_pkg::STATUS_CAPACITY));
        else begin
          unit_blk[n_units] = c.value[5:0];
          n_units++;
          blk_size[c.value]++;
          if (int'(c.value) + 1 > n_blks) n_blks = int'(c.value) + 1;
          if (c.last) begin
            if (n_labels == 0) begin
              clear_state();
              expected_q.push_back(status_only(bra_pkg::STATUS_NO_LABELS));
            end else begin
              phase = PH_RAND;
              cur_blk = 0;
              base = 0;
              next_block();
            end
          end
        end
      end
      bra_pkg::FUNC_DRAW: begin
        if (phase != PH_RAND)
          expected_q.push_back(status_only(bra_pkg::STATUS_NOT_READY));
        else apply_draw(c.rand_fraction);
      end
      default: begin
        if (phase != PH_READY || fpos >= n_units) begin
          expected_q.push_back(status_only(bra_pkg::STATUS_NOT_READY));
        end else begin
          r = '0;
          idx = fpos;
          b = unit_blk[idx];
          p = blk_ptr[b];
          if (p > 0 && p <= 1024) begin
            r.treatment = pool[p - 1];
            blk_ptr[b] = p - 1;
          end
          r.unit_index = idx[9:0];
          r.last_unit = (idx + 1 == n_units);
          r.status = bra_pkg::STATUS_OK;
          fpos++;
          expected_q.push_back(r);
          if (r.last_unit) clear_state();
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_q.delete();
      errors <= 0;
    end else begin
      if (start && !busy) predict_item(cmd);
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors <= errors + 1;
        end else if (expected_q[0] !== result) begin
          $display("%0t: mismatch expected %h actual %h", $time, expected_q[0], result);
          expected_q.pop_front();
          errors <= errors + 1;
        end else begin
          expected_q.pop_front();
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_blocked_random_assignment.sv
`timescale 1ns / 1ps
// Top of the blocked random assignment testbench: clock, reset, stimulus
// sessions and verdict. Depends on bra_pkg, bra_checker and the block.
module tb_blocked_random_assignment;

  logic             clk, rst, start, busy, done;
  bra_pkg::cmd_t    cmd;
  bra_pkg::result_t result;
  int               errors, pending;
  int               n_sent, idle_pct, stall_cnt;

  blocked_random_assignment u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  bra_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] f, logic [15:0] v, logic [31:0] u, logic l);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{func: f, value: v, rand_fraction: u, last: l};
    do @(posedge clk); while (busy);
    n_sent++;
    if (n_sent == 200) idle_pct = 80;
    if (n_sent == 400) idle_pct = 0;
  endtask

  task automatic send_noise(logic [1:0] f);
    send_item(f, 16'($urandom), $urandom, 1'($urandom));
  endtask

  function automatic logic [31:0] pick_frac(int mode, int k);
    case (mode)
      1: return 32'h0;
      2: return 32'hFFFF_FFFF;
      3: return k[0] ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_session(int nl, int nu, int nb, int mode);
    int sizes [64];
    int draws, nlab, id;
    logic [1:0] f;
    for (int b = 0; b < 64; b++) sizes[b] = 0;
    for (int k = 0; k < nl; k++)
      send_item(bra_pkg::FUNC_LABEL,
                mode != 0 ? (k[0] ? 16'hFFFF : 16'h0) : 16'($urandom),
                $urandom, 1'($urandom));
    nlab = nl > 16 ? 16 : nl;
    for (int k = 0; k < nu; k++) begin
      if ($urandom_range(99) < 5)
        send_item(bra_pkg::FUNC_UNIT, 16'($urandom_range(64, 65535)), $urandom,
                  1'($urandom));
      id = $urandom_range(nb - 1);
      sizes[id]++;
      send_item(bra_pkg::FUNC_UNIT, 16'(id), $urandom, k == nu - 1);
    end
    if (nlab > 0) begin
      draws = 0;
      for (int b = 0; b < 64; b++)
        if (sizes[b] > 0) draws += sizes[b] % nlab + sizes[b];
      for (int k = 0; k < draws; k++) begin
        if ($urandom_range(99) < 8) begin
          f = 2'($urandom_range(2));
          send_noise(f == bra_pkg::FUNC_DRAW ? bra_pkg::FUNC_FETCH : f);
        end
        send_item(bra_pkg::FUNC_DRAW, 16'($urandom), pick_frac(mode, k), 1'($urandom));
      end
      for (int k = 0; k < nu; k++) begin
        if ($urandom_range(99) < 8) send_noise(2'($urandom_range(2)));
        send_noise(bra_pkg::FUNC_FETCH);
      end
      if ($urandom_range(99) < 20) send_noise(bra_pkg::FUNC_FETCH);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    n_sent = 0;
    idle_pct = 14;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_noise(bra_pkg::FUNC_FETCH);
    send_noise(bra_pkg::FUNC_DRAW);
    run_session(0, 2, 4, 0);
    run_session(3, 5, 64, 3);
    run_session(17, 4, 2, 1);
    run_session(1, 3, 1, 2);
    while (n_sent < 500) begin
      if ($urandom_range(99) < 10)
        run_session($urandom_range(0, 17), $urandom_range(40, 120),
                    $urandom_range(1, 64), 0);
      else
        run_session($urandom_range(1, 17), $urandom_range(1, 20),
                    $urandom_range(1, 8), 0);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
